[src/assert_macros.svh]
// Assertion macros for the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define PND_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define PND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/pnd_pkg.sv]
// Shared widths, note tables and stage structs for the pitch-to-note deviation block
`default_nettype none

package pnd_pkg;

  // Number formats
  localparam int FREQ_FRAC_BITS = 6;
  localparam int TOL_FRAC_BITS  = 16;

  // Port field widths
  localparam int IN_W       = 18;
  localparam int TOL_W      = 16;
  localparam int NOTE_IDX_W = 4;
  localparam int OCT_W      = 3;
  localparam int NOM_OUT_W  = 18;
  localparam int DEV_OUT_W  = 19;

  localparam int MAX_OCT     = 6;
  localparam int NOTES       = 12;
  localparam int TOL_RESET   = 655;
  localparam int NOM_OUT_MAX = (1 << NOM_OUT_W) - 1;
  localparam int DEV_LIM     = (1 << (DEV_OUT_W - 1)) - 1;

  // Internal widths: a base note stays below 2^(FREQ_FRAC_BITS+7)
  localparam int NOTE_W    = FREQ_FRAC_BITS + 7;
  localparam int MID_W     = NOTE_W + 1;
  localparam int NOM_W     = NOTE_W + MAX_OCT;
  localparam int DEVI_W    = ((NOM_W > IN_W) ? NOM_W : IN_W) + 1;
  localparam int MAG_W     = DEVI_W - 1;
  localparam int PROD_W    = TOL_W + NOM_W;
  localparam int SMAG_W    = MAG_W + TOL_FRAC_BITS;
  localparam int CMPT_W    = (PROD_W > SMAG_W) ? PROD_W : SMAG_W;
  localparam int OCT_CMP_W = ((IN_W + 2) > (MID_W + MAX_OCT + 1)) ? (IN_W + 2)
                                                                 : (MID_W + MAX_OCT + 1);
  localparam int NOTE_CMP_W = ((IN_W + 1) > MID_W) ? (IN_W + 1) : MID_W;
  localparam int SAT_W      = (NOM_W > NOM_OUT_W) ? NOM_W : NOM_OUT_W;

  // Base octave E1..D#2 in 1/1024 Hz
  localparam int unsigned BASE1024 [NOTES] = '{
    42192, 44701, 47359, 50175, 53159, 56320,
    59669, 63217, 66976, 70959, 75178, 79649
  };

  // Base note rounded half up to the input step; index NOTES is the next E
  function automatic logic [NOTE_W-1:0] note_const(input int i);
    int unsigned r;
    if (i >= NOTES) begin
      r = (BASE1024[0] * 2 + (1 << (10 - FREQ_FRAC_BITS))) >> (11 - FREQ_FRAC_BITS);
      r = r * 2;
    end else begin
      r = (BASE1024[i] * 2 + (1 << (10 - FREQ_FRAC_BITS))) >> (11 - FREQ_FRAC_BITS);
    end
    return r[NOTE_W-1:0];
  endfunction

  // Twice the midpoint between note i and note i+1
  function automatic logic [MID_W-1:0] mid_const(input int i);
    return MID_W'(note_const(i)) + MID_W'(note_const(i + 1));
  endfunction

  // Four times the upper octave midpoint of octave i-1
  function automatic logic [OCT_CMP_W-1:0] oct_thr(input int i);
    return OCT_CMP_W'(mid_const(NOTES - 1)) << i;
  endfunction

  // Classify stage contents
  typedef struct packed {
    logic [IN_W-1:0]       freq;
    logic [OCT_W-1:0]      octave;
    logic [NOTE_IDX_W-1:0] note;
    logic                  oor;
  } cls_t;

  // Arithmetic stage contents
  typedef struct packed {
    logic [NOTE_IDX_W-1:0] note;
    logic [OCT_W-1:0]      octave;
    logic                  oor;
    logic [NOM_W-1:0]      nominal;
    logic [DEVI_W-1:0]     dev;
    logic [MAG_W-1:0]      mag;
    logic [PROD_W-1:0]     prod;
  } arith_t;

  // Result item
  typedef struct packed {
    logic [DEV_OUT_W-1:0]  deviation;
    logic [NOM_OUT_W-1:0]  nominal;
    logic [OCT_W-1:0]      octave;
    logic [NOTE_IDX_W-1:0] note;
    logic                  oor;
  } res_t;

endpackage

`default_nettype wire

[src/pnd_classify.sv]
// Octave and nearest-note selection from the measured frequency
`default_nettype none

module pnd_classify (
  input  wire logic [pnd_pkg::IN_W-1:0] freq,
  output pnd_pkg::cls_t                 cls
);

  logic [pnd_pkg::OCT_CMP_W-1:0]  f4;
  logic [pnd_pkg::IN_W:0]         f2_norm;
  logic [pnd_pkg::OCT_W-1:0]      octave;
  logic [pnd_pkg::NOTE_IDX_W-1:0] note;

  // Pick the octave against the scaled D#/E midpoints; a tie stays low
  always_comb begin
    f4     = pnd_pkg::OCT_CMP_W'({freq, 2'b00});
    octave = '0;
    for (int i = 1; i <= pnd_pkg::MAX_OCT; i++) begin
      if (f4 > pnd_pkg::oct_thr(i)) octave = pnd_pkg::OCT_W'(i);
    end
  end

  // Scale the input down to the base octave; exact because the midpoints carry zero low bits
  assign f2_norm = {freq, 1'b0} >> octave;

  // Pick the note; a tie goes to the upper note
  always_comb begin
    note = '0;
    for (int i = 0; i < pnd_pkg::NOTES - 1; i++) begin
      if (pnd_pkg::NOTE_CMP_W'(f2_norm) >= pnd_pkg::NOTE_CMP_W'(pnd_pkg::mid_const(i)))
        note = pnd_pkg::NOTE_IDX_W'(i + 1);
    end
  end

  assign cls.freq   = freq;
  assign cls.octave = octave;
  assign cls.note   = note;
  assign cls.oor    = f4 > pnd_pkg::oct_thr(pnd_pkg::MAX_OCT + 1);

endmodule

`default_nettype wire

[src/pnd_arith.sv]
// Nominal frequency, raw deviation and tolerance product
`default_nettype none

module pnd_arith (
  input  wire pnd_pkg::cls_t             cls,
  input  wire logic [pnd_pkg::TOL_W-1:0] tolerance_fraction,
  output pnd_pkg::arith_t                ar
);

  logic [pnd_pkg::NOTE_W-1:0] base;
  logic [pnd_pkg::NOM_W-1:0]  nominal;
  logic [pnd_pkg::DEVI_W-1:0] dev;
  logic [pnd_pkg::DEVI_W-1:0] dev_neg;

  // Look up the base-octave note
  always_comb begin
    base = '0;
    for (int i = 0; i < pnd_pkg::NOTES; i++) begin
      if (cls.note == pnd_pkg::NOTE_IDX_W'(i)) base = pnd_pkg::note_const(i);
    end
  end

  // Scale to the octave and take measured minus nominal
  assign nominal = pnd_pkg::NOM_W'(base) << cls.octave;
  assign dev     = pnd_pkg::DEVI_W'(cls.freq) - pnd_pkg::DEVI_W'(nominal);
  assign dev_neg = -dev;

  assign ar.note    = cls.note;
  assign ar.octave  = cls.octave;
  assign ar.oor     = cls.oor;
  assign ar.nominal = nominal;
  assign ar.dev     = dev;
  assign ar.mag     = dev[pnd_pkg::DEVI_W-1] ? dev_neg[pnd_pkg::MAG_W-1:0]
                                             : dev[pnd_pkg::MAG_W-1:0];
  assign ar.prod    = pnd_pkg::PROD_W'(tolerance_fraction) * pnd_pkg::PROD_W'(nominal);

endmodule

`default_nettype wire

[src/pnd_finish.sv]
// Tolerance test, saturation and out-of-range forcing of the result
`default_nettype none

module pnd_finish (
  input  wire pnd_pkg::arith_t ar,
  output pnd_pkg::res_t        res
);

  localparam logic signed [pnd_pkg::DEVI_W-1:0] DEV_HI = pnd_pkg::DEVI_W'(pnd_pkg::DEV_LIM);
  localparam logic signed [pnd_pkg::DEVI_W-1:0] DEV_LO = -DEV_HI;

  logic                              in_tol;
  logic signed [pnd_pkg::DEVI_W-1:0] dev_tol;
  logic signed [pnd_pkg::DEVI_W-1:0] dev_sat;
  logic [pnd_pkg::NOM_OUT_W-1:0]     nom_sat;

  // Zero the deviation when |dev| is strictly below tolerance times nominal
  assign in_tol  = (pnd_pkg::CMPT_W'(ar.mag) << pnd_pkg::TOL_FRAC_BITS)
                   < pnd_pkg::CMPT_W'(ar.prod);
  assign dev_tol = in_tol ? '0 : $signed(ar.dev);

  // Clamp deviation and nominal to the output ranges
  always_comb begin
    if (dev_tol > DEV_HI)      dev_sat = DEV_HI;
    else if (dev_tol < DEV_LO) dev_sat = DEV_LO;
    else                       dev_sat = dev_tol;
    if (pnd_pkg::SAT_W'(ar.nominal) > pnd_pkg::SAT_W'(pnd_pkg::NOM_OUT_MAX))
      nom_sat = pnd_pkg::NOM_OUT_W'(pnd_pkg::NOM_OUT_MAX);
    else
      nom_sat = pnd_pkg::NOM_OUT_W'(ar.nominal);
  end

  // Drop every field but the flag when out of range
  always_comb begin
    res.oor = ar.oor;
    if (ar.oor) begin
      res.note      = '0;
      res.octave    = '0;
      res.nominal   = '0;
      res.deviation = '0;
    end else begin
      res.note      = ar.note;
      res.octave    = ar.octave;
      res.nominal   = nom_sat;
      res.deviation = dev_sat[pnd_pkg::DEV_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

[src/pitch_to_note_deviation.sv]
// Top level of the pitch-to-note deviation block: stage registers and stream handshake
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | tdata: measured_freq
//   m_axis   | out       | tdata: note_index, octave, nominal_freq, deviation;
//            |           | tuser: out_of_range
//   cfg      | in        | tolerance_fraction, written when cfg_we is high
//
// One item per cycle sustained while m_axis is not stalled.
// The path runs through four registers: input, classify, arithmetic, result.
// Reset clears every stage valid and loads tolerance_fraction with 655.
// A stall on m_axis holds the result and fills the stages behind it; s_axis_tready
// falls only once every stage holds an item.
`default_nettype none

module pitch_to_note_deviation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [17:0] measured_freq, [23:18] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [3:0] note_index, [6:4] octave,
                                           // [24:7] nominal_freq, [43:25] deviation,
                                           // [47:44] zero
  output logic             m_axis_tuser,   // [0] out_of_range
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [pnd_pkg::TOL_W-1:0] tolerance_fraction;
  logic [pnd_pkg::IN_W-1:0]  freq_in;
  logic                      v_in;
  pnd_pkg::cls_t             cls_next;
  pnd_pkg::cls_t             cls;
  logic                      v_cls;
  pnd_pkg::arith_t           ar_next;
  pnd_pkg::arith_t           ar;
  logic                      v_ar;
  pnd_pkg::res_t             res_next;
  pnd_pkg::res_t             res;
  logic                      rdy_out;
  logic                      rdy_ar;
  logic                      rdy_cls;
  logic                      rdy_in;

  // Stage ready chain: a stage may load when empty or when the stage after it moves
  assign rdy_out       = !m_axis_tvalid || m_axis_tready;
  assign rdy_ar        = !v_ar || rdy_out;
  assign rdy_cls       = !v_cls || rdy_ar;
  assign rdy_in        = !v_in || rdy_cls;
  assign s_axis_tready = rdy_in;

  // Hold the tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_fraction <= pnd_pkg::TOL_W'(pnd_pkg::TOL_RESET);
    end else if (cfg_we) begin
      tolerance_fraction <= cfg_wdata;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in          <= 1'b0;
      v_cls         <= 1'b0;
      v_ar          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (rdy_in)  v_in          <= s_axis_tvalid;
      if (rdy_cls) v_cls         <= v_in;
      if (rdy_ar)  v_ar          <= v_cls;
      if (rdy_out) m_axis_tvalid <= v_ar;
    end
  end

  // Stage payloads advance only with a valid item behind them
  always_ff @(posedge clk) begin
    if (rdy_in && s_axis_tvalid) freq_in <= s_axis_tdata[pnd_pkg::IN_W-1:0];
    if (rdy_cls && v_in)         cls     <= cls_next;
    if (rdy_ar && v_cls)         ar      <= ar_next;
    if (rdy_out && v_ar)         res     <= res_next;
  end

  pnd_classify u_classify (
    .freq (freq_in),
    .cls  (cls_next)
  );

  pnd_arith u_arith (
    .cls                (cls),
    .tolerance_fraction (tolerance_fraction),
    .ar                 (ar_next)
  );

  pnd_finish u_finish (
    .ar  (ar),
    .res (res_next)
  );

  // Pack the result item
  assign m_axis_tdata = {4'b0000, res.deviation, res.nominal, res.octave, res.note};
  assign m_axis_tuser = res.oor;

endmodule

`default_nettype wire

[src/pnd_checker.sv]
// Port-level assertions for the pitch-to-note deviation block, bound to its top level
`default_nettype none
`include "assert_macros.svh"

module pnd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic        out_ok;
  logic        oor_item;
  logic        oor_zero;
  logic        fields_ok;
  logic        nom_ok;
  logic        out_free;
  logic        out_stall;
  logic [49:0] out_word;

  assign out_ok    = m_axis_tvalid && !m_axis_tuser;
  assign oor_item  = m_axis_tvalid && m_axis_tuser;
  assign oor_zero  = m_axis_tdata == 48'd0;
  assign fields_ok = (m_axis_tdata[3:0] <= 4'd11) && (m_axis_tdata[6:4] <= 3'd6);
  assign nom_ok    = m_axis_tdata[24:7] != 18'd0;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

  // An out-of-range item carries zero in every field
  `PND_ASSERT_NOW(a_oor_zero, oor_item, oor_zero, "out-of-range item with non-zero fields")

  // Note index and octave stay within their ranges
  `PND_ASSERT_NOW(a_ranges, out_ok, fields_ok, "note index or octave out of range")

  // An in-range item always has a non-zero nominal frequency
  `PND_ASSERT_NOW(a_nominal, out_ok, nom_ok, "zero nominal on an in-range item")

  // A stalled result holds
  `PND_ASSERT_NEXT(a_hold, out_stall, $stable(out_word), "stalled result changed")

  // The input is ready whenever the output side can move
  `PND_ASSERT_NOW(a_in_ready, out_free, s_axis_tready, "input stalled while output is free")

endmodule

bind pitch_to_note_deviation pnd_checker u_pnd_checker (.*);

`default_nettype wire
